[rtl/dpt_pkg.sv]
// ----------------------------------------------------------------------------
// dpt_pkg: shared types and constants of the dirty page tracker
// Payload structs, command and error codes, sequencer states.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int unsigned NumPagesDef   = 32;
  localparam int unsigned PageBytesDef  = 256;
  localparam int unsigned DirtySlotsDef = 8;
  localparam logic [13:0] RegionReset   = 14'd8192;
  localparam logic [5:0]  RefMax        = 6'h3F;

  typedef enum logic [2:0] {
    OP_ACQ_RD  = 3'd0,
    OP_ACQ_RW  = 3'd1,
    OP_RELEASE = 3'd2,
    OP_SUSPEND = 3'd3,
    OP_RESTORE = 3'd4,
    OP_NOP5    = 3'd5,
    OP_NOP6    = 3'd6,
    OP_NOP7    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ACT_DONE  = 2'd0,
    ACT_WBACK = 2'd1,
    ACT_LOAD  = 2'd2,
    ACT_ERROR = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RANGE    = 3'd1,
    ERR_REF_OVF  = 3'd2,
    ERR_DIRTY    = 3'd3,
    ERR_REL_IDLE = 3'd4
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVICT,
    ST_EVICT_CHK,
    ST_MTF,
    ST_DROP,
    ST_FINISH,
    ST_SUSP,
    ST_SUSP_RM,
    ST_REST,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] byte_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] page_index;
    logic [2:0] error_code;
    logic [3:0] dirty_count;
    logic [5:0] active_count;
    logic [5:0] pages_saved;
    logic       last;
  } out_item_t;

endpackage

[rtl/dirty_page_tracker_with_lru_writeback.sv]
// ----------------------------------------------------------------------------
// dirty_page_tracker_with_lru_writeback
// Page state tracker with a move-to-front list of dirty pages.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one command: acquire
//   read, acquire read-write, release, suspend or restore. out channel
//   (out_valid_o/out_ready_i/out_data_o) returns write-back and load commands,
//   then a final done or error transfer with last set. On the cfg channel,
//   users write region_bytes only while idle; the block does not enforce it.
// Timing: one item at a time; in_ready_o is high only in idle. A sequencer
//   visits one list slot or one page per cycle through a single compare and
//   update path. Acquire may run an eviction scan and a list shift; suspend
//   walks pages in order until none is dirty, restore walks every page, and
//   suspend scans list slots to remove each idle page it cleans out.
// Each result sits in an output register; the sequencer holds while the
//   receiver stalls and resumes once the transfer happens.
// Reset: all pages unreferenced, clean and unloaded, list empty, counts zero,
//   region_bytes 8192. Page attribute and list valid bits are flip-flops
//   cleared at once; no clearing pass.
// ----------------------------------------------------------------------------
module dirty_page_tracker_with_lru_writeback #(
  parameter int unsigned NUM_PAGES   = dpt_pkg::NumPagesDef,
  parameter int unsigned PAGE_BYTES  = dpt_pkg::PageBytesDef,
  parameter int unsigned DIRTY_SLOTS = dpt_pkg::DirtySlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dpt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dpt_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [13:0]        cfg_data_i
);
  import dpt_pkg::*;

  localparam int unsigned PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned SW = (DIRTY_SLOTS > 1) ? $clog2(DIRTY_SLOTS) : 1;
  localparam int unsigned SHIFT = $clog2(PAGE_BYTES);

  // state storage
  logic [7:0] attr_q [NUM_PAGES];
  logic [5:0] list_q [DIRTY_SLOTS];
  logic [DIRTY_SLOTS-1:0] lval_q;
  logic [3:0] dirty_q;
  logic [5:0] active_q;
  logic [13:0] region_q;

  // sequencer registers
  state_e state_q, state_d;
  logic [2:0] op_q;
  logic [5:0] page_q;
  logic [SW:0] slot_q;   // wide enough to hold DIRTY_SLOTS
  logic [PW:0] pcnt_q;   // wide enough to hold NUM_PAGES
  logic [5:0] carry_q;
  logic [5:0] saved_q;
  logic       evicted_q;
  out_item_t  out_q;
  logic       ovalid_q;
  state_e     ret_q;     // state to resume after an emit

  logic stall;
  assign stall = ovalid_q && !out_ready_i;

  assign in_ready_o  = (state_q == ST_IDLE) && !ovalid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  // decode of the incoming offset
  logic [15:0] pnum_full;
  logic        in_range;
  assign pnum_full = in_data_i.byte_offset >> SHIFT;
  assign in_range  = ({2'b00, region_q} >= in_data_i.byte_offset)
                     && (pnum_full < 16'(NUM_PAGES));

  // shared unit: one page or slot examined per cycle unless the output stalls
  logic [SW-1:0] sidx;
  logic [PW-1:0] pidx;
  logic [7:0]    pa;       // attributes of page_q
  logic [7:0]    ca;       // attributes of the list entry at slot
  logic [5:0]    sent;
  logic          sval;
  logic [7:0]    wa;       // attributes of walked page
  assign sidx = slot_q[SW-1:0];
  assign pidx = pcnt_q[PW-1:0];
  assign pa   = attr_q[page_q[PW-1:0]];
  assign sent = list_q[sidx];
  assign sval = lval_q[sidx];
  assign ca   = (sent < 6'(NUM_PAGES)) ? attr_q[sent[PW-1:0]] : 8'h00;
  assign wa   = attr_q[pidx];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i && in_ready_o) state_d = ST_CHECK;
      ST_CHECK:    state_d = ST_EMIT;
      ST_EVICT:    state_d = ST_EVICT;
      ST_EVICT_CHK: state_d = ST_EMIT;
      ST_MTF:      state_d = ST_MTF;
      ST_DROP:     state_d = ST_DROP;
      ST_FINISH:   state_d = ST_EMIT;
      ST_SUSP:     state_d = ST_SUSP;
      ST_SUSP_RM:  state_d = ST_SUSP_RM;
      ST_REST:     state_d = ST_REST;
      ST_EMIT:     state_d = ST_EMIT;
      default:     state_d = ST_IDLE;
    endcase
  end

  // sequencer: all datapath work, one step per cycle while the output does not stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_IDLE;
      ovalid_q  <= 1'b0;
      lval_q    <= '0;
      dirty_q   <= '0;
      active_q  <= '0;
      region_q  <= RegionReset;
      evicted_q <= 1'b0;
      for (int i = 0; i < NUM_PAGES; i++) attr_q[i] <= 8'h00;
    end else begin
      if (cfg_valid_i && cfg_ready_o) region_q <= cfg_data_i;
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      if (!stall) begin
        case (state_q)
          ST_IDLE: begin
            if (in_valid_i && in_ready_o) begin
              op_q    <= in_data_i.opcode;
              page_q  <= in_range ? pnum_full[5:0] : 6'd0;
              saved_q <= '0;
              pcnt_q  <= '0;
              slot_q  <= (SW+1)'(DIRTY_SLOTS - 1);
              evicted_q <= 1'b0;
              if (!in_range && (in_data_i.opcode == OP_ACQ_RD ||
                  in_data_i.opcode == OP_ACQ_RW || in_data_i.opcode == OP_RELEASE))
                page_q <= 6'h3F;  // marks out-of-range for the check step
              state_q <= ST_CHECK;
            end
          end
          ST_CHECK: begin
            case (op_q)
              OP_ACQ_RD, OP_ACQ_RW: begin
                if (page_q >= 6'(NUM_PAGES)) emit_res(ACT_ERROR, 0, ERR_RANGE, 1'b1, ST_IDLE);
                else if (pa[5:0] == RefMax) emit_res(ACT_ERROR, 0, ERR_REF_OVF, 1'b1, ST_IDLE);
                else if (op_q == OP_ACQ_RW && 32'(dirty_q) >= DIRTY_SLOTS)
                  state_q <= ST_EVICT;
                else if (op_q == OP_ACQ_RW) begin
                  begin_mtf();
                end else state_q <= ST_FINISH;
              end
              OP_RELEASE: begin
                if (page_q >= 6'(NUM_PAGES)) emit_res(ACT_ERROR, 0, ERR_RANGE, 1'b1, ST_IDLE);
                else if (pa[5:0] == 6'd0)
                  emit_res(ACT_ERROR, 0, ERR_REL_IDLE, 1'b1, ST_IDLE);
                else begin
                  attr_q[page_q[PW-1:0]] <= pa - 8'd1;
                  if (pa[5:0] == 6'd1 && active_q != 0) begin
                    active_q <= active_q - 6'd1;
                    emit_cnt(ACT_DONE, 0, ERR_NONE, dirty_q, active_q - 6'd1, 0, 1'b1);
                  end else emit_cnt(ACT_DONE, 0, ERR_NONE, dirty_q, active_q, 0, 1'b1);
                  state_q <= ST_IDLE;
                end
              end
              OP_SUSPEND: state_q <= ST_SUSP;
              OP_RESTORE: state_q <= ST_REST;
              default: emit_res(ACT_DONE, 0, ERR_NONE, 1'b1, ST_IDLE);
            endcase
          end
          // scan list from back for an evictable page
          ST_EVICT: begin
            if (sval && ca[5:0] == 6'd0 && ca[7] && ca[6]) begin
              attr_q[sent[PW-1:0]] <= ca & ~8'h40;
              lval_q[sidx] <= 1'b0;
              if (dirty_q != 0) begin
                dirty_q <= dirty_q - 4'd1;
                emit_cnt(ACT_WBACK, sent, ERR_NONE, dirty_q - 4'd1, active_q, 0, 1'b0);
              end else emit_cnt(ACT_WBACK, sent, ERR_NONE, dirty_q, active_q, 0, 1'b0);
              ret_q <= ST_EVICT_CHK;
              state_q <= ST_EMIT;
            end else if (slot_q == 0) state_q <= ST_EVICT_CHK;
            else slot_q <= slot_q - 1'b1;
          end
          ST_EVICT_CHK: begin
            if (32'(dirty_q) >= DIRTY_SLOTS)
              emit_res(ACT_ERROR, 0, ERR_DIRTY, 1'b1, ST_IDLE);
            else begin_mtf();
          end
          // move-to-front, one slot per cycle while the output does not stall
          ST_MTF: begin
            if (!sval || sent == page_q) begin
              list_q[sidx] <= carry_q;
              lval_q[sidx] <= 1'b1;
              slot_q <= slot_q + 1'b1;
              state_q <= ST_DROP;
            end else begin
              list_q[sidx] <= carry_q;
              carry_q <= sent;
              if (32'(slot_q) == DIRTY_SLOTS - 1) state_q <= ST_FINISH;
              else slot_q <= slot_q + 1'b1;
            end
          end
          ST_DROP: begin
            if (32'(slot_q) >= DIRTY_SLOTS) state_q <= ST_FINISH;
            else if (sval && sent == carry_q) begin
              lval_q[sidx] <= 1'b0;
              state_q <= ST_FINISH;
            end else slot_q <= slot_q + 1'b1;
          end
          ST_FINISH: begin
            if (!pa[7]) begin
              attr_q[page_q[PW-1:0]] <= pa | 8'h80;
              emit_cnt(ACT_LOAD, page_q, ERR_NONE, dirty_q, active_q, 0, 1'b0);
              ret_q <= ST_FINISH;
              state_q <= ST_EMIT;
            end else begin
              attr_q[page_q[PW-1:0]] <= pa + 8'd1;
              if (pa[5:0] == 6'd0) begin
                active_q <= active_q + 6'd1;
                emit_cnt(ACT_DONE, 0, ERR_NONE, dirty_q, active_q + 6'd1, 0, 1'b1);
              end else emit_cnt(ACT_DONE, 0, ERR_NONE, dirty_q, active_q, 0, 1'b1);
              state_q <= ST_IDLE;
            end
          end
          // suspend: walk pages in order
          ST_SUSP: begin
            if (32'(pcnt_q) >= NUM_PAGES || dirty_q == 0)
              emit_cnt(ACT_DONE, 0, ERR_NONE, dirty_q, active_q, saved_q, 1'b1);
            else if (wa[6]) begin
              saved_q <= saved_q + 6'd1;
              if (wa[5:0] == 6'd0) begin
                attr_q[pidx] <= wa & ~8'h40;
                dirty_q <= dirty_q - 4'd1;
                slot_q <= (SW+1)'(DIRTY_SLOTS - 1);
                state_q <= ST_SUSP_RM;
              end else begin
                emit_cnt(ACT_WBACK, 6'(pcnt_q), ERR_NONE, dirty_q, active_q, 0, 1'b0);
                pcnt_q <= pcnt_q + 1'b1;
                ret_q <= ST_SUSP;
                state_q <= ST_EMIT;
              end
            end else pcnt_q <= pcnt_q + 1'b1;
            if (32'(pcnt_q) >= NUM_PAGES || dirty_q == 0) state_q <= ST_IDLE;
          end
          ST_SUSP_RM: begin
            if ((sval && sent == 6'(pcnt_q)) || slot_q == 0) begin
              if (sval && sent == 6'(pcnt_q)) lval_q[sidx] <= 1'b0;
              emit_cnt(ACT_WBACK, 6'(pcnt_q), ERR_NONE, dirty_q, active_q, 0, 1'b0);
              pcnt_q <= pcnt_q + 1'b1;
              ret_q <= ST_SUSP;
              state_q <= ST_EMIT;
            end else slot_q <= slot_q - 1'b1;
          end
          // restore: reload referenced pages, mark unreferenced ones unloaded
          ST_REST: begin
            if (32'(pcnt_q) >= NUM_PAGES) begin
              emit_cnt(ACT_DONE, 0, ERR_NONE, dirty_q, active_q, 0, 1'b1);
              state_q <= ST_IDLE;
            end else begin
              pcnt_q <= pcnt_q + 1'b1;
              if (wa[5:0] != 6'd0) begin
                attr_q[pidx] <= wa | 8'h80;
                emit_cnt(ACT_LOAD, 6'(pcnt_q), ERR_NONE, dirty_q, active_q, 0, 1'b0);
                ret_q <= ST_REST;
                state_q <= ST_EMIT;
              end else attr_q[pidx] <= wa & ~8'h80;
            end
          end
          // result handed to the output register; continue after it
          ST_EMIT: state_q <= ret_q;
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  // output register load with explicit counts
  function automatic out_item_t mk(act_e a, logic [5:0] p, err_e e, logic [3:0] d,
                                   logic [5:0] ac, logic [5:0] s, logic l);
    out_item_t o;
    o.action = a; o.page_index = p; o.error_code = e; o.dirty_count = d;
    o.active_count = ac; o.pages_saved = s; o.last = l;
    return o;
  endfunction

  // these helpers write registers in the clocked block; emit_cnt and emit_res touch only output and state registers
  task automatic emit_cnt(act_e a, logic [5:0] p, err_e e, logic [3:0] d,
                          logic [5:0] ac, logic [5:0] s, logic l);
    out_q    <= mk(a, p, e, d, ac, s, l);
    ovalid_q <= 1'b1;
  endtask

  task automatic emit_res(act_e a, logic [5:0] p, err_e e, logic l, state_e nxt);
    out_q    <= mk(a, p, e, dirty_q, active_q, 6'd0, l);
    ovalid_q <= 1'b1;
    state_q  <= nxt;
  endtask

  task automatic begin_mtf();
    if (!pa[6]) begin
      dirty_q <= dirty_q + 4'd1;
      attr_q[page_q[PW-1:0]] <= pa | 8'h40;
    end
    carry_q <= page_q;
    slot_q  <= '0;
    state_q <= ST_MTF;
  endtask

`ifndef ASSERT_OFF
  // no new item while a command is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o) else $error("ready outside idle");
  // output register never overwritten while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o)) else $error("result lost");
  // dirty count never exceeds list capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(dirty_q) <= DIRTY_SLOTS)) else $error("dirty count overflow");
  // an accepted item leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_CHECK)) else $error("item dropped");
`endif

endmodule

[bench/tb_dirty_page_tracker_with_lru_writeback.sv]
// ----------------------------------------------------------------------------
// tb_dirty_page_tracker_with_lru_writeback
// Drives page commands and region writes into the tracker, predicts every
// write-back, load, done and error transfer, and checks them in order.
// ----------------------------------------------------------------------------
module tb_dirty_page_tracker_with_lru_writeback;
  import dpt_pkg::*;

  localparam int unsigned Pages = 32;
  localparam int unsigned Slots = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [13:0] cfg_data_i = '0;

  dirty_page_tracker_with_lru_writeback dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // Clock: period 8
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted tracker state
  logic [7:0]  page_attr [Pages];
  logic [5:0]  dirty_list [Slots];
  logic        dirty_slot_valid [Slots];
  int          pages_dirty;
  int          pages_active;
  logic [13:0] region_size;

  out_item_t step_results[$];
  out_item_t expected_results[$];
  bit        failed = 1'b0;
  int        hold_request = 0;
  bit        stall_free = 1'b0;

  // Result of the current command, stamped with the counts so far
  function automatic void emit(act_e act, int pg, err_e err, int saved);
    out_item_t r;
    r.action       = act;
    r.page_index   = 6'(pg);
    r.error_code   = err;
    r.dirty_count  = 4'(pages_dirty);
    r.active_count = 6'(pages_active);
    r.pages_saved  = 6'(saved);
    r.last         = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void make_clean(int p);
    page_attr[p][6] = 1'b0;
    if (pages_dirty > 0) pages_dirty--;
  endfunction

  // Acquired page to the front; the others shift back to its slot or a hole
  function automatic void move_to_front(logic [5:0] pg);
    logic [5:0] carry, t;
    carry = pg;
    for (int i = 0; i < Slots; i++) begin
      if (!dirty_slot_valid[i] || dirty_list[i] == pg) begin
        dirty_slot_valid[i] = 1'b1;
        dirty_list[i] = carry;
        for (int j = i + 1; j < Slots; j++) begin
          if (dirty_slot_valid[j] && dirty_list[j] == carry) begin
            dirty_slot_valid[j] = 1'b0;
            return;
          end
        end
        return;
      end
      t = dirty_list[i];
      dirty_list[i] = carry;
      carry = t;
    end
  endfunction

  function automatic bit out_of_region(logic [15:0] off);
    return (off > {2'b00, region_size}) || (off[15:13] != 3'd0);
  endfunction

  function automatic void acquire_page(logic [15:0] off, bit rw);
    int p;
    logic [7:0] a;
    if (out_of_region(off)) begin
      emit(ACT_ERROR, 0, ERR_RANGE, 0);
      return;
    end
    p = off[12:8];
    if (page_attr[p][5:0] == RefMax) begin
      emit(ACT_ERROR, 0, ERR_REF_OVF, 0);
      return;
    end
    if (rw) begin
      if (pages_dirty >= Slots) begin
        // evict the oldest idle, loaded, modified page
        for (int i = Slots - 1; i >= 0; i--) begin
          if (dirty_slot_valid[i]) begin
            a = (dirty_list[i] < Pages) ? page_attr[dirty_list[i]] : 8'h00;
            if (a[5:0] == 6'd0 && a[7] && a[6]) begin
              make_clean(dirty_list[i]);
              dirty_slot_valid[i] = 1'b0;
              emit(ACT_WBACK, dirty_list[i], ERR_NONE, 0);
              break;
            end
          end
        end
        if (pages_dirty >= Slots) begin
          emit(ACT_ERROR, 0, ERR_DIRTY, 0);
          return;
        end
      end
      if (!page_attr[p][6]) begin
        pages_dirty++;
        page_attr[p][6] = 1'b1;
      end
      move_to_front(6'(p));
    end
    if (!page_attr[p][7]) begin
      page_attr[p][7] = 1'b1;
      emit(ACT_LOAD, p, ERR_NONE, 0);
    end
    if (page_attr[p][5:0] == 6'd0) pages_active++;
    page_attr[p] = page_attr[p] + 8'd1;
    emit(ACT_DONE, 0, ERR_NONE, 0);
  endfunction

  function automatic void release_page(logic [15:0] off);
    int p;
    if (out_of_region(off)) begin
      emit(ACT_ERROR, 0, ERR_RANGE, 0);
      return;
    end
    p = off[12:8];
    if (page_attr[p][5:0] == 6'd0) begin
      emit(ACT_ERROR, 0, ERR_REL_IDLE, 0);
      return;
    end
    page_attr[p] = page_attr[p] - 8'd1;
    if (page_attr[p][5:0] == 6'd0 && pages_active > 0) pages_active--;
    emit(ACT_DONE, 0, ERR_NONE, 0);
  endfunction

  function automatic void suspend_pages();
    int saved;
    saved = 0;
    for (int p = 0; p < Pages; p++) begin
      if (pages_dirty == 0) break;
      if (page_attr[p][6]) begin
        saved++;
        if (page_attr[p][5:0] == 6'd0) begin
          make_clean(p);
          for (int i = Slots - 1; i >= 0; i--) begin
            if (dirty_slot_valid[i] && dirty_list[i] == 6'(p)) begin
              dirty_slot_valid[i] = 1'b0;
              break;
            end
          end
        end
        emit(ACT_WBACK, p, ERR_NONE, 0);
      end
    end
    emit(ACT_DONE, 0, ERR_NONE, saved);
  endfunction

  function automatic void restore_pages();
    for (int p = 0; p < Pages; p++) begin
      page_attr[p][7] = 1'b0;
      if (page_attr[p][5:0] != 6'd0) begin
        page_attr[p][7] = 1'b1;
        emit(ACT_LOAD, p, ERR_NONE, 0);
      end
    end
    emit(ACT_DONE, 0, ERR_NONE, 0);
  endfunction

  // Work out all transfers one command causes and queue them
  function automatic void predict_command(in_item_t cmd);
    step_results.delete();
    case (op_e'(cmd.opcode))
      OP_ACQ_RD:  acquire_page(cmd.byte_offset, 1'b0);
      OP_ACQ_RW:  acquire_page(cmd.byte_offset, 1'b1);
      OP_RELEASE: release_page(cmd.byte_offset);
      OP_SUSPEND: suspend_pages();
      OP_RESTORE: restore_pages();
      default:    emit(ACT_DONE, 0, ERR_NONE, 0);
    endcase
    step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Send one command; valid drops in the step of the transfer
  task automatic send_command(op_e op, logic [15:0] off);
    in_item_t cmd;
    cmd.opcode = op;
    cmd.byte_offset = off;
    repeat (pick_gap()) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    predict_command(cmd);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Region register is only written with the tracker idle
  task automatic write_region(logic [13:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    region_size = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] page_offset(int p);
    return {3'b000, 5'(p), 8'($urandom)};
  endfunction

  // Receiver: random stalls, plus one long hold on request
  always @(posedge clk_i) begin
    int r;
    static int stall_left = 0;
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (hold_request > 0) begin
      stall_left = hold_request - 1;
      hold_request = 0;
      out_ready_i <= 1'b0;
    end else if (stall_free) begin
      out_ready_i <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_ready_i <= 1'b0;
      end
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer %h", out_data_o);
        failed = 1'b1;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data_o.action !== exp_r.action) begin
          $error("action: expected %0d actual %0d", exp_r.action, out_data_o.action);
          failed = 1'b1;
        end
        if (out_data_o.page_index !== exp_r.page_index) begin
          $error("page_index: expected %0d actual %0d",
                 exp_r.page_index, out_data_o.page_index);
          failed = 1'b1;
        end
        if (out_data_o.error_code !== exp_r.error_code) begin
          $error("error_code: expected %0d actual %0d",
                 exp_r.error_code, out_data_o.error_code);
          failed = 1'b1;
        end
        if (out_data_o.dirty_count !== exp_r.dirty_count) begin
          $error("dirty_count: expected %0d actual %0d",
                 exp_r.dirty_count, out_data_o.dirty_count);
          failed = 1'b1;
        end
        if (out_data_o.active_count !== exp_r.active_count) begin
          $error("active_count: expected %0d actual %0d",
                 exp_r.active_count, out_data_o.active_count);
          failed = 1'b1;
        end
        if (out_data_o.pages_saved !== exp_r.pages_saved) begin
          $error("pages_saved: expected %0d actual %0d",
                 exp_r.pages_saved, out_data_o.pages_saved);
          failed = 1'b1;
        end
        if (out_data_o.last !== exp_r.last) begin
          $error("last: expected %0d actual %0d", exp_r.last, out_data_o.last);
          failed = 1'b1;
        end
      end
    end
  end

  // Every opcode, including the unused ones
  task automatic test_opcodes();
    send_command(OP_ACQ_RD, 16'd0);
    send_command(OP_ACQ_RW, 16'h0100);
    send_command(OP_RELEASE, 16'd0);
    send_command(OP_SUSPEND, 16'd0);
    send_command(OP_RESTORE, 16'd0);
    send_command(OP_NOP5, 16'hFFFF);
    send_command(OP_NOP6, 16'd0);
    send_command(OP_NOP7, 16'h5A5A);
    send_command(OP_RELEASE, 16'h0100);
    send_command(OP_SUSPEND, 16'd0);
    send_command(OP_RELEASE, 16'h0100);   // page now idle
  endtask

  // Region edge is inclusive; offsets past the last page fail too
  task automatic test_bounds();
    send_command(OP_ACQ_RD, 16'hFFFF);
    send_command(OP_RELEASE, 16'hFFFF);
    send_command(OP_ACQ_RD, 16'd8192);
    send_command(OP_ACQ_RD, 16'd8191);
    send_command(OP_RELEASE, 16'd8191);
    write_region(14'd300);
    send_command(OP_ACQ_RW, 16'd300);
    send_command(OP_ACQ_RW, 16'd301);
    send_command(OP_RELEASE, 16'd300);
    write_region(14'd1);
    send_command(OP_ACQ_RD, 16'd1);
    send_command(OP_ACQ_RD, 16'd2);
    send_command(OP_RELEASE, 16'd0);
    write_region(14'h3FFF);
    send_command(OP_ACQ_RD, 16'h3FFF);
    write_region(RegionReset);
  endtask

  // Count saturates at 63 with an error instead of wrapping
  task automatic test_ref_overflow();
    repeat (63) send_command(OP_ACQ_RD, 16'h0280);
    send_command(OP_ACQ_RD, 16'h02FF);
    send_command(OP_ACQ_RW, 16'h0200);
    repeat (63) send_command(OP_RELEASE, 16'h0200);
    send_command(OP_RELEASE, 16'h0200);
  endtask

  // Full dirty list: error while all are active, eviction once one is idle
  task automatic test_dirty_limit();
    for (int p = 8; p < 16; p++) send_command(OP_ACQ_RW, page_offset(p));
    send_command(OP_ACQ_RW, page_offset(20));
    send_command(OP_RELEASE, page_offset(11));
    send_command(OP_ACQ_RW, page_offset(20));
    send_command(OP_ACQ_RW, page_offset(8));
    send_command(OP_SUSPEND, 16'd0);
    for (int p = 8; p < 16; p++) send_command(OP_RELEASE, page_offset(p));
    send_command(OP_RESTORE, 16'd0);
    send_command(OP_SUSPEND, 16'd0);
    send_command(OP_RELEASE, page_offset(20));
    send_command(OP_SUSPEND, 16'd0);
  endtask

  // One random command, mostly acquire/release on a few pages
  task automatic random_command(int hot_pages);
    int r;
    r = $urandom_range(0, 99);
    if (r < 33) send_command(OP_ACQ_RD, page_offset($urandom_range(0, hot_pages - 1)));
    else if (r < 58) send_command(OP_ACQ_RW, page_offset($urandom_range(0, hot_pages - 1)));
    else if (r < 88) send_command(OP_RELEASE, page_offset($urandom_range(0, hot_pages - 1)));
    else if (r < 92) send_command(OP_SUSPEND, 16'($urandom));
    else if (r < 95) send_command(OP_RESTORE, 16'($urandom));
    else if (r < 98) send_command(op_e'($urandom_range(0, 2)), 16'($urandom));
    else send_command(op_e'($urandom_range(5, 7)), 16'($urandom));
  endtask

  // Receiver holds off long while commands keep coming; then sender waits
  task automatic test_backpressure();
    hold_request = 300;
    repeat (6) random_command(12);
    wait_drained();
    stall_free = 1'b1;
    repeat (10) random_command(12);
    stall_free = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_mix();
    repeat (110) random_command(14);
    write_region(14'h3FFF);
    repeat (30) random_command(32);
    write_region(14'd1);
    repeat (15) random_command(2);
    write_region(14'($urandom_range(1, 8192)));
    repeat (40) random_command(32);
    write_region(RegionReset);
    repeat (10) random_command(10);
  endtask

  initial begin
    foreach (page_attr[i]) page_attr[i] = '0;
    foreach (dirty_list[i]) begin
      dirty_list[i] = '0;
      dirty_slot_valid[i] = 1'b0;
    end
    pages_dirty = 0;
    pages_active = 0;
    region_size = RegionReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_opcodes();
    test_bounds();
    test_ref_overflow();
    test_dirty_limit();
    test_backpressure();
    test_random_mix();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(8 * 3000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
rtl/dpt_pkg.sv
rtl/dirty_page_tracker_with_lru_writeback.sv
bench/tb_dirty_page_tracker_with_lru_writeback.sv
